/* rtl/core/bhpq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhpq_pkg: shared types and constants for the binary heap priority queue
// Transfer payload structs, heap entry layout, sequencer states and codes.
// ----------------------------------------------------------------------------
package bhpq_pkg;

   localparam int CAPACITY = 1023;
   localparam int KEY_BITS = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int TOTAL_W  = 10;

   localparam logic [31:0] KEY_MASK = 32'((33'd1 << KEY_BITS) - 33'd1);

   localparam logic       OP_INSERT    = 1'b0;
   localparam logic       OP_POLL      = 1'b1;
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic        op;
      logic [31:0] item_key;
      logic [31:0] item_payload;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [31:0]        out_key;
      logic [31:0]        out_payload;
      logic [TOTAL_W-1:0] entry_total;
      logic               is_empty;
   } rsp_type;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] payload;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_RD,
      S_UP_CMP,
      S_POLL_LD,
      S_DN_RD,
      S_DN_SEL,
      S_DN_CMP,
      S_DN_ONE,
      S_PLACE,
      S_RESP
   } state_type;

endpackage : bhpq_pkg
`default_nettype wire

/* rtl/core/binary_heap_priority_queue_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Sequence: an insert runs S_UP_RD and S_UP_CMP per level climbed, then S_PLACE and
//   S_RESP; a poll runs S_POLL_LD, then S_DN_RD, S_DN_SEL and S_DN_CMP per level
//   descended (S_DN_ONE for a lone left child), then S_PLACE and S_RESP; a refused item goes straight to S_RESP.
// Throughput: one item at a time; req_stall stays high from accept until the result
//   transfer, so the sift walk (one RAM access and one compare per step) holds off the next request.
// Reset: synchronous active-high; clears count, sequencer and max_first. The
//   heap RAM is not cleared: only slots 1..count are ever used.
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_core
// Binary min/max heap in a 1-indexed RAM, sifted by a small sequencer around
// one shared key comparator.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_core
   import bhpq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   // request channel
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_item,
   // result channel
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_item,
   // configuration: max_first
   input  wire logic    csr_we,
   input  wire logic    csr_wdata
);

   // ------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;     // entries held
   logic [CNT_W-1:0] idx_ff, idx_in;         // hole position during a sift
   entry_type        hold_ff, hold_in;       // entry being placed
   entry_type        best_ff, best_in;       // chosen child during sift-down
   logic [CNT_W-1:0] best_idx_ff, best_idx_in;
   entry_type        out_ff, out_in;         // polled root
   logic [1:0]       status_ff, status_in;
   logic             max_first_ff;

   // heap RAM: one write port, two registered read ports
   entry_type        heap_store_ff [0:CAPACITY];
   logic [CNT_W-1:0] rd_a_addr, rd_b_addr;
   entry_type        rd_a_ff, rd_b_ff;
   logic             wr_en;
   logic [CNT_W-1:0] wr_addr;
   entry_type        wr_data;

   // shared comparator: cmp_after is true when key a orders strictly after b
   logic [31:0]      cmp_a, cmp_b;
   logic             cmp_after;

   logic             req_xfer, rsp_xfer;
   logic [CNT_W:0]   left_w, right_w, count_w;
   logic [CNT_W-1:0] left_idx, right_idx, parent_idx;

   assign req_xfer   = req_valid && !req_stall;
   assign rsp_xfer   = rsp_valid && !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = (state_ff == S_RESP);

   assign count_w    = {1'b0, count_ff};
   assign left_w     = {idx_ff, 1'b0};
   assign right_w    = {idx_ff, 1'b1};
   assign left_idx   = left_w[CNT_W-1:0];
   assign right_idx  = right_w[CNT_W-1:0];
   assign parent_idx = {1'b0, idx_ff[CNT_W-1:1]};

   assign cmp_after  = max_first_ff ? (cmp_a < cmp_b) : (cmp_a > cmp_b);

   // ------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (req_item.op == OP_INSERT) begin
                  state_in = (count_w >= (CNT_W+1)'(CAPACITY)) ? S_RESP : S_UP_RD;
               end else begin
                  state_in = (count_ff == '0) ? S_RESP : S_POLL_LD;
               end
            end
         end
         S_UP_RD:   state_in = (idx_ff > CNT_W'(1)) ? S_UP_CMP : S_PLACE;
         S_UP_CMP:  state_in = cmp_after ? S_UP_RD : S_PLACE;
         S_POLL_LD: state_in = S_DN_RD;
         S_DN_RD: begin
            if (right_w <= count_w) begin
               state_in = S_DN_SEL;
            end else if (left_w <= count_w) begin
               state_in = S_DN_ONE;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_DN_SEL:  state_in = S_DN_CMP;
         S_DN_CMP:  state_in = cmp_after ? S_DN_RD : S_PLACE;
         S_DN_ONE:  state_in = S_PLACE;
         S_PLACE:   state_in = S_RESP;
         S_RESP:    state_in = rsp_xfer ? S_IDLE : S_RESP;
         default:   state_in = S_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Datapath control
   // ------------------------------------------------------------------
   always_comb begin
      count_in    = count_ff;
      idx_in      = idx_ff;
      hold_in     = hold_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      out_in      = out_ff;
      status_in   = status_ff;
      rd_a_addr   = parent_idx;
      rd_b_addr   = right_idx;
      wr_en       = 1'b0;
      wr_addr     = idx_ff;
      wr_data     = hold_ff;
      cmp_a       = hold_ff.key;
      cmp_b       = rd_a_ff.key;
      case (state_ff)
         S_IDLE: begin
            // root and last slot are fetched together for a poll
            rd_a_addr = CNT_W'(1);
            rd_b_addr = count_ff;
            if (req_xfer) begin
               out_in    = '0;
               status_in = STATUS_OK;
               if (req_item.op == OP_INSERT) begin
                  if (count_w >= (CNT_W+1)'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                  end else begin
                     count_in        = count_ff + CNT_W'(1);
                     idx_in          = count_ff + CNT_W'(1);
                     hold_in.key     = req_item.item_key & KEY_MASK;
                     hold_in.payload = req_item.item_payload;
                  end
               end else if (count_ff == '0) begin
                  status_in = STATUS_EMPTY;
               end
            end
         end
         S_UP_RD: begin
            rd_a_addr = parent_idx;
         end
         S_UP_CMP: begin
            // parent orders after the new entry: pull it down into the hole
            cmp_a = rd_a_ff.key;
            cmp_b = hold_ff.key;
            if (cmp_after) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_data = rd_a_ff;
               idx_in  = parent_idx;
            end
         end
         S_POLL_LD: begin
            out_in   = rd_a_ff;
            hold_in  = rd_b_ff;
            count_in = count_ff - CNT_W'(1);
            idx_in   = CNT_W'(1);
         end
         S_DN_RD: begin
            rd_a_addr = left_idx;
            rd_b_addr = right_idx;
         end
         S_DN_SEL: begin
            // left child wins only when strictly better than the right
            cmp_a = rd_b_ff.key;
            cmp_b = rd_a_ff.key;
            if (cmp_after) begin
               best_in     = rd_a_ff;
               best_idx_in = left_idx;
            end else begin
               best_in     = rd_b_ff;
               best_idx_in = right_idx;
            end
         end
         S_DN_CMP: begin
            cmp_a = hold_ff.key;
            cmp_b = best_ff.key;
            if (cmp_after) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_data = best_ff;
               idx_in  = best_idx_ff;
            end
         end
         S_DN_ONE: begin
            // lone left child, checked once
            cmp_a = hold_ff.key;
            cmp_b = rd_a_ff.key;
            if (cmp_after) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_data = rd_a_ff;
               idx_in  = left_idx;
            end
         end
         S_PLACE: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = hold_ff;
         end
         S_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         max_first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_we) begin
            max_first_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      hold_ff     <= hold_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      out_ff      <= out_in;
      status_ff   <= status_in;
   end

   // heap RAM
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= heap_store_ff[rd_a_addr];
      rd_b_ff <= heap_store_ff[rd_b_addr];
   end

   // ------------------------------------------------------------------
   // Result
   // ------------------------------------------------------------------
   always_comb begin
      rsp_item.status      = status_ff;
      rsp_item.out_key     = out_ff.key;
      rsp_item.out_payload = out_ff.payload;
      rsp_item.entry_total = TOTAL_W'(count_ff);
      rsp_item.is_empty    = (count_ff == '0);
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_w <= (CNT_W+1)'(CAPACITY))
      else $error("entry count above capacity");

   // polling the last entry still parks it in the root slot
   a_wr_in_heap : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_addr != '0 &&
                 ({1'b0, wr_addr} <= count_w || wr_addr == CNT_W'(1))))
      else $error("heap write outside occupied slots");

   a_busy_after_xfer : assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall)
      else $error("request channel open while an item is in progress");

   a_sift_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DN_RD || state_ff == S_UP_RD) |->
         ({1'b0, idx_ff} <= count_w || idx_ff == CNT_W'(1)))
      else $error("sift cursor beyond occupied slots");

   a_refused_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status_ff != STATUS_OK) |-> (out_ff == '0))
      else $error("refused item carries a nonzero entry");

endmodule : binary_heap_priority_queue_core
`default_nettype wire

/* tb/sv/heap_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_result_checker
// Watches the request, result and register ports of the heap queue, keeps
// its own heap image to predict every result and compares each result
// transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module heap_result_checker
   import bhpq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  wire req_type req_item,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp_item,
   input  wire logic    csr_we,
   input  wire logic    csr_wdata,
   output int           err_count,
   output int           waiting
);

   // heap image, 1-indexed like the block's RAM
   logic [31:0] heap_key [1:CAPACITY];
   logic [31:0] heap_pay [1:CAPACITY];
   int          entry_count;
   logic        order_max;
   rsp_type     pending_results [$];

   // true when key a must sit strictly below key b in the heap
   function automatic bit ranks_after(logic [31:0] a, logic [31:0] b);
      return order_max ? (a < b) : (a > b);
   endfunction

   function automatic rsp_type heap_apply(req_type it);
      rsp_type     r;
      int          i;
      int          best;
      bit          done;
      logic [31:0] mk;
      logic [31:0] mp;
      logic [31:0] tk;
      logic [31:0] tp;
      r = '0;
      r.status = STATUS_OK;
      if (it.op == OP_INSERT) begin
         if (entry_count >= CAPACITY) begin
            r.status = STATUS_FULL;
         end else begin
            entry_count++;
            i = entry_count;
            heap_key[i] = it.item_key & KEY_MASK;
            heap_pay[i] = it.item_payload;
            // sift up: equal keys stay put
            while (i > 1 && ranks_after(heap_key[i / 2], heap_key[i])) begin
               tk = heap_key[i];
               tp = heap_pay[i];
               heap_key[i] = heap_key[i / 2];
               heap_pay[i] = heap_pay[i / 2];
               heap_key[i / 2] = tk;
               heap_pay[i / 2] = tp;
               i = i / 2;
            end
         end
      end else if (entry_count == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         mk = heap_key[entry_count];
         mp = heap_pay[entry_count];
         r.out_key = heap_key[1];
         r.out_payload = heap_pay[1];
         entry_count--;
         i = 1;
         done = 1'b0;
         // sift down; right child wins ties
         while (!done && 2 * i + 1 <= entry_count) begin
            best = ranks_after(heap_key[2 * i + 1], heap_key[2 * i]) ? 2 * i : 2 * i + 1;
            if (ranks_after(mk, heap_key[best])) begin
               heap_key[i] = heap_key[best];
               heap_pay[i] = heap_pay[best];
               i = best;
            end else begin
               done = 1'b1;
            end
         end
         // lone left child
         if (!done && 2 * i <= entry_count && ranks_after(mk, heap_key[2 * i])) begin
            heap_key[i] = heap_key[2 * i];
            heap_pay[i] = heap_pay[2 * i];
            i = 2 * i;
         end
         heap_key[i] = mk;
         heap_pay[i] = mp;
      end
      r.entry_total = entry_count[TOTAL_W-1:0];
      r.is_empty = (entry_count == 0);
      return r;
   endfunction

   function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      int      bad;
      bad = 0;
      if (reset) begin
         entry_count = 0;
         order_max = 1'b0;
         pending_results.delete();
         err_count <= 0;
         waiting <= 0;
      end else begin
         if (csr_we)
            order_max = csr_wdata;
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result transfer with no request outstanding");
               bad++;
            end else begin
               want = pending_results.pop_front();
               bad += field_diff("status", 32'(want.status), 32'(rsp_item.status));
               bad += field_diff("out_key", want.out_key, rsp_item.out_key);
               bad += field_diff("out_payload", want.out_payload, rsp_item.out_payload);
               bad += field_diff("entry_total", 32'(want.entry_total),
                                 32'(rsp_item.entry_total));
               bad += field_diff("is_empty", 32'(want.is_empty), 32'(rsp_item.is_empty));
            end
         end
         if (req_valid && !req_stall)
            pending_results.push_back(heap_apply(req_item));
         err_count <= err_count + bad;
         waiting <= pending_results.size();
      end
   end

endmodule : heap_result_checker

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the heap queue with directed and random insert/poll transfers under
// several sender/receiver idle mixes and both pop orders, lets the checker
// predict and compare, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top
   import bhpq_pkg::*;
();

   // watchdog limit, well above the length of a correct run
   localparam int CYCLE_LIMIT = 1000000;
   // drain margin at the end
   localparam int TAIL_CYCLES = 40;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_item;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;
   logic    csr_we;
   logic    csr_wdata;
   int      err_count;
   int      waiting;

   int      send_idle_pct;
   int      rsp_stall_pct;
   int      cycle_count = 0;

   binary_heap_priority_queue_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   heap_result_checker i_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .err_count (err_count),
      .waiting   (waiting)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Receiver side: stall is random per cycle and independent of rsp_valid,
   // so stalls land on every phase of the sift walk.
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Mostly full-range keys, with the extremes and a narrow band mixed in so
   // that equal keys (no swap) show up often. Narrow mode forces duplicates.
   function automatic logic [31:0] pick_key(bit narrow);
      if (narrow)
         return $urandom_range(7);
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2, 3:    return $urandom_range(15);
         default: return $urandom();
      endcase
   endfunction

   // One request transfer. Called right after a rising edge. Valid is only
   // lowered for a sender gap, never dropped and raised in the same step.
   task automatic push_item(logic op, logic [31:0] key, logic [31:0] payload);
      req_type it;
      it.op = op;
      it.item_key = key;
      it.item_payload = payload;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Wait until the checker holds no open prediction. The extra edge first
   // lets the count cover a transfer accepted on the calling edge.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (waiting != 0)
         @(posedge clock);
   endtask

   // max_first is only written with the block idle.
   task automatic set_order(logic max_first);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= max_first;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic run_mix(int count, int poll_pct, bit narrow);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < poll_pct)
            push_item(OP_POLL, $urandom(), $urandom());
         else
            push_item(OP_INSERT, pick_key(narrow), $urandom());
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_item      = '0;
      csr_we        = 1'b0;
      csr_wdata     = 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, min-first, no idling: empty poll, extremes, equal keys
      // (arrival order kept for the payloads), then drain past empty.
      set_order(1'b0);
      push_item(OP_POLL, 32'h0, 32'h0);
      push_item(OP_INSERT, 32'd5, 32'hA5A5_0001);
      push_item(OP_INSERT, 32'd5, 32'hA5A5_0002);
      push_item(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
      push_item(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
      push_item(OP_INSERT, 32'd3, 32'h5A5A_5A5A);
      push_item(OP_INSERT, 32'd9, 32'h1234_5678);
      for (int n = 0; n < 7; n++)
         push_item(OP_POLL, 32'h0, 32'h0);

      // Directed, max-first: extremes and a duplicate pair.
      set_order(1'b1);
      push_item(OP_INSERT, 32'h0000_0000, 32'h0000_0011);
      push_item(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0022);
      push_item(OP_INSERT, 32'd7, 32'h0000_0033);
      push_item(OP_INSERT, 32'd7, 32'h0000_0044);
      push_item(OP_INSERT, 32'd100, 32'h0000_0055);
      for (int n = 0; n < 6; n++)
         push_item(OP_POLL, 32'h0, 32'h0);

      // Random, min-first, no idling, full-range keys and then keys from a tiny range;
      // some polls hit empty.
      set_order(1'b0);
      run_mix(60, 45, 1'b0);
      run_mix(60, 45, 1'b1);

      // Fill to capacity and past it (refused inserts, all count bits set),
      // max-first, stepping through the idle mixes as the heap grows.
      set_order(1'b1);
      for (int n = 0; n < CAPACITY + 3; n++) begin
         if (n < 340) begin
            send_idle_pct = 71;
            rsp_stall_pct = 0;
         end else if (n < 680) begin
            send_idle_pct = 0;
            rsp_stall_pct = 71;
         end else begin
            send_idle_pct = 6;
            rsp_stall_pct = 6;
         end
         push_item(OP_INSERT, pick_key(1'b0), $urandom());
      end

      // Deep sift-down walks from a full heap, no idling.
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      for (int n = 0; n < 60; n++)
         push_item(OP_POLL, $urandom(), $urandom());

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0 && waiting == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule : tb_top
